// ----- rtl/mte_pkg.sv -----
package mte_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int ACC_BITS  = 2 * WORD_BITS + 4;
    localparam int ADDR_BITS = 6;
    localparam int QUO_BITS  = 2 * FRAC_BITS + 1;

    typedef logic signed [WORD_BITS-1:0]   t_word;
    typedef logic signed [2*WORD_BITS-1:0] t_prod;
    typedef logic signed [ACC_BITS-1:0]    t_acc;
    typedef logic [ADDR_BITS-1:0]          t_addr;

    localparam t_word ONE_Q = t_word'(1) <<< FRAC_BITS;

    // Regions of the shared matrix memory.
    localparam t_addr CUR_BASE  = t_addr'(0);
    localparam t_addr OPD_BASE  = t_addr'(16);
    localparam t_addr TMP_BASE  = t_addr'(32);
    localparam t_addr TERM_BASE = t_addr'(48);

    typedef enum logic [2:0] {
        OP_IDENT = 3'd0,
        OP_SCALE = 3'd1,
        OP_TRANS = 3'd2,
        OP_LOAD  = 3'd3,
        OP_MUL   = 3'd4,
        OP_INV   = 3'd5,
        OP_XFORM = 3'd6,
        OP_READ  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        SRC_ZERO  = 3'd0,
        SRC_ONE   = 3'd1,
        SRC_MEM   = 3'd2,
        SRC_VEC   = 3'd3,
        SRC_RECIP = 3'd4
    } t_src;

    typedef enum logic [1:0] {
        DST_MEM = 2'd0,
        DST_OUT = 2'd1,
        DST_DET = 2'd2
    } t_dst;

    // One multiply-accumulate step of the sequencer.
    typedef struct packed {
        t_src  a_src;
        t_addr a_addr;
        t_src  b_src;
        t_addr b_addr;
        logic  neg;
        logic  first;
        logic  last;
        t_dst  dst;
        t_addr dst_addr;
    } t_term;

    // Column choices of the six terms of a 3x3 determinant, and their signs.
    localparam logic [1:0] PERM_A [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1};
    localparam logic [1:0] PERM_B [6] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
    localparam logic [1:0] PERM_C [6] = '{2'd2, 2'd0, 2'd1, 2'd1, 2'd0, 2'd2};
    localparam logic       PERM_N [6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    // The n-th index of 0..3 once index i is left out.
    function automatic logic [1:0] skip_idx(logic [1:0] i, logic [1:0] n);
        return (n >= i) ? n + 2'd1 : n;
    endfunction

    function automatic t_addr el_addr(t_addr base, logic [1:0] col, logic [1:0] row);
        return base + {2'b00, col, row};
    endfunction

    function automatic logic [3:0] last_group(t_op op, logic [1:0] ph);
        logic [3:0] n;
        case (op)
            OP_IDENT: n = 4'd15;
            OP_SCALE: n = 4'd11;
            OP_MUL:   n = 4'd15;
            OP_INV: begin
                case (ph)
                    2'd0:    n = 4'd5;
                    2'd3:    n = 4'd15;
                    default: n = 4'd0;
                endcase
            end
            default:  n = 4'd3;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] last_term(t_op op, logic [1:0] ph);
        logic [2:0] n;
        case (op)
            OP_TRANS: n = 3'd3;
            OP_XFORM: n = 3'd3;
            OP_MUL:   n = (ph == 2'd0) ? 3'd3 : 3'd0;
            OP_INV: begin
                case (ph)
                    2'd1:    n = 3'd5;
                    2'd2:    n = 3'd3;
                    default: n = 3'd0;
                endcase
            end
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic t_term make_term(t_op op, logic [1:0] ph, logic [1:0] row,
                                        logic [3:0] q, logic [3:0] g, logic [2:0] k);
        t_term      t;
        logic [1:0] cr;
        logic [1:0] cc;
        logic [1:0] kk;
        logic [2:0] pi;
        t  = '0;
        cr = q[1:0];
        cc = q[3:2];
        kk = k[1:0];
        t.a_src = SRC_MEM;
        t.b_src = SRC_ONE;
        t.dst   = DST_MEM;
        case (op)
            OP_IDENT: begin
                t.a_src    = (g[1:0] == g[3:2]) ? SRC_ONE : SRC_ZERO;
                t.dst_addr = el_addr(CUR_BASE, g[3:2], g[1:0]);
            end
            OP_SCALE: begin
                t.a_addr   = el_addr(CUR_BASE, g[3:2], g[1:0]);
                t.b_src    = SRC_VEC;
                t.b_addr   = t_addr'(g[3:2]);
                t.dst_addr = t.a_addr;
            end
            OP_TRANS: begin
                t.a_addr   = el_addr(CUR_BASE, kk, g[1:0]);
                t.b_src    = (kk == 2'd3) ? SRC_ONE : SRC_VEC;
                t.b_addr   = t_addr'(kk);
                t.dst_addr = el_addr(CUR_BASE, 2'd3, g[1:0]);
            end
            OP_LOAD: begin
                t.a_src    = SRC_VEC;
                t.a_addr   = t_addr'(g[1:0]);
                t.dst_addr = el_addr(OPD_BASE, g[1:0], row);
            end
            OP_MUL: begin
                if (ph == 2'd0) begin
                    t.a_addr   = el_addr(OPD_BASE, g[3:2], kk);
                    t.b_src    = SRC_MEM;
                    t.b_addr   = el_addr(CUR_BASE, kk, g[1:0]);
                    t.dst_addr = el_addr(TMP_BASE, g[3:2], g[1:0]);
                end else begin
                    t.a_addr   = el_addr(TMP_BASE, g[3:2], g[1:0]);
                    t.dst_addr = el_addr(CUR_BASE, g[3:2], g[1:0]);
                end
            end
            OP_INV: begin
                case (ph)
                    2'd0: begin
                        pi         = g[2:0];
                        t.a_addr   = el_addr(CUR_BASE, skip_idx(cr, PERM_A[pi]),
                                             skip_idx(cc, 2'd0));
                        t.b_src    = SRC_MEM;
                        t.b_addr   = el_addr(CUR_BASE, skip_idx(cr, PERM_B[pi]),
                                             skip_idx(cc, 2'd1));
                        t.dst_addr = TERM_BASE + t_addr'(pi);
                    end
                    2'd1: begin
                        pi         = k;
                        t.a_addr   = TERM_BASE + t_addr'(pi);
                        t.b_src    = SRC_MEM;
                        t.b_addr   = el_addr(CUR_BASE, skip_idx(cr, PERM_C[pi]),
                                             skip_idx(cc, 2'd2));
                        t.neg      = PERM_N[pi] ^ cr[0] ^ cc[0];
                        t.dst_addr = el_addr(TMP_BASE, cc, cr);
                    end
                    2'd2: begin
                        t.a_addr = el_addr(CUR_BASE, 2'd0, kk);
                        t.b_src  = SRC_MEM;
                        t.b_addr = el_addr(TMP_BASE, kk, 2'd0);
                        t.dst    = DST_DET;
                    end
                    default: begin
                        t.a_addr   = el_addr(TMP_BASE, g[3:2], g[1:0]);
                        t.b_src    = SRC_RECIP;
                        t.dst_addr = el_addr(CUR_BASE, g[3:2], g[1:0]);
                    end
                endcase
            end
            OP_XFORM: begin
                t.a_src    = SRC_VEC;
                t.a_addr   = t_addr'(kk);
                t.b_src    = SRC_MEM;
                t.b_addr   = el_addr(CUR_BASE, kk, g[1:0]);
                t.dst      = DST_OUT;
                t.dst_addr = t_addr'(g[1:0]);
            end
            default: begin
                t.a_addr   = el_addr(CUR_BASE, g[1:0], row);
                t.dst      = DST_OUT;
                t.dst_addr = t_addr'(g[1:0]);
            end
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/matrix4_transform_engine.sv -----
// 4x4 homogeneous transform engine, signed Q16.16, column-major storage.
// Input channel (s_axis): one transaction carries one operation in tuser and
// the vector x, y, z, w in tdata. Output channel (m_axis): every input
// transaction yields exactly one output transaction with the result vector
// (transform or read row, zero otherwise) and the singular and overflow flags.
// All matrices live in one 64-entry memory with two read ports; a sequencer
// issues one multiply-accumulate step per cycle while issuing, to a shared
// 32x32 multiplier followed by a wide accumulator and a floor-and-saturate
// stage. Each phase of an operation ends in a pipeline drain. Steps per
// operation: identity 16, scale 12, translate 16, load row 4, read row 4,
// transform 16, multiply 64 + 16 steps with two drains, invert
// 16 x (6 + 6) + 4 + 16 steps with 34 drains plus a reciprocal division.
// One item is worked on at a time; s_axis_tready is high while idle.
// Reset clears both kept matrices to zero through per-entry valid bits and
// empties the output register. When the receiver stalls the finished result
// waits in the output register, and the engine holds its last result until
// the register frees up before accepting the next transaction.
module matrix4_transform_engine
    import mte_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // x, y, z, w (32 bits each)
    input  logic [4:0]   s_axis_tuser,   // op (3 bits), row (2 bits)
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // out_x, out_y, out_z, out_w
    output logic [1:0]   m_axis_tuser    // singular, overflow
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam t_acc ACC_MAX = (t_acc'(1) <<< (WORD_BITS - 1)) - t_acc'(1);
    localparam t_acc ACC_MIN = -ACC_MAX - t_acc'(1);
    localparam logic signed [QUO_BITS:0] Q_MAX = (QUO_BITS+1)'(ACC_MAX);
    localparam logic signed [QUO_BITS:0] Q_MIN = (QUO_BITS+1)'(ACC_MIN);
    localparam logic [5:0] DIV_LAST = 6'(QUO_BITS - 1);

    t_state      r_state;
    t_op         r_op;
    logic [1:0]  r_row;
    t_word       r_vec [4];
    logic [1:0]  r_ph;
    logic [3:0]  r_q;
    logic [3:0]  r_g;
    logic [2:0]  r_k;
    logic        r_ov;
    logic        r_sing;
    t_word       r_res [4];
    t_word       r_det;
    t_word       r_recip;

    // Shared matrix memory: current, operand, scratch and cofactor terms.
    t_word       r_mem [64];
    logic [31:0] r_vld;
    t_word       r_rd_a;
    t_word       r_rd_b;
    logic        r_rd_a_ok;
    logic        r_rd_b_ok;

    logic        r_s1_v;
    t_term       r_s1;
    logic        r_s2_v;
    t_term       r_s2;
    t_prod       r_prod;
    logic        r_s3_v;
    t_term       r_s3;
    t_acc        r_acc;

    logic [31:0] r_dmag;
    logic        r_dneg;
    logic [31:0] r_rem;
    logic [QUO_BITS-1:0] r_quo;
    logic [5:0]  r_dcnt;

    logic        r_out_v;
    t_word       r_out [4];
    logic        r_out_sing;
    logic        r_out_ov;

    t_term       w_iss;
    logic [3:0]  w_lg;
    logic [2:0]  w_lk;
    t_addr       w_rd_a_addr;
    t_addr       w_rd_b_addr;
    t_word       w_a;
    t_word       w_b;
    t_prod       w_prod;
    t_acc        w_addend;
    t_acc        n_acc;
    t_acc        w_shift;
    t_word       w_fin;
    logic        w_fin_ov;
    logic        w_wr;
    logic        w_pipe_busy;
    logic [32:0] w_rem_sh;
    logic        w_qbit;
    logic [QUO_BITS-1:0] n_quo;
    logic signed [QUO_BITS:0] w_qs;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out[3], r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = {r_out_ov, r_out_sing};

    // Step generation.
    always_comb begin
        w_lg  = last_group(r_op, r_ph);
        w_lk  = last_term(r_op, r_ph);
        w_iss = make_term(r_op, r_ph, r_row, r_q, r_g, r_k);
        w_iss.first = (r_k == 3'd0);
        w_iss.last  = (r_k == w_lk);
        w_rd_a_addr = w_iss.a_addr;
        w_rd_b_addr = w_iss.b_addr;
    end

    // Operand selection, product and accumulation.
    always_comb begin
        case (r_s1.a_src)
            SRC_MEM:   w_a = r_rd_a_ok ? r_rd_a : '0;
            SRC_VEC:   w_a = r_vec[r_s1.a_addr[1:0]];
            SRC_ONE:   w_a = ONE_Q;
            SRC_RECIP: w_a = r_recip;
            default:   w_a = '0;
        endcase
        case (r_s1.b_src)
            SRC_MEM:   w_b = r_rd_b_ok ? r_rd_b : '0;
            SRC_VEC:   w_b = r_vec[r_s1.b_addr[1:0]];
            SRC_ONE:   w_b = ONE_Q;
            SRC_RECIP: w_b = r_recip;
            default:   w_b = '0;
        endcase
        w_prod   = t_prod'(w_a) * t_prod'(w_b);
        w_addend = r_s2.neg ? -t_acc'(r_prod) : t_acc'(r_prod);
        n_acc    = (r_s2.first ? '0 : r_acc) + w_addend;
    end

    // Floor by the fraction width, then saturate to the word range.
    always_comb begin
        w_shift  = r_acc >>> FRAC_BITS;
        w_fin_ov = 1'b0;
        if (w_shift > ACC_MAX) begin
            w_fin    = t_word'(ACC_MAX);
            w_fin_ov = 1'b1;
        end else if (w_shift < ACC_MIN) begin
            w_fin    = t_word'(ACC_MIN);
            w_fin_ov = 1'b1;
        end else begin
            w_fin = t_word'(w_shift);
        end
        w_wr        = r_s3_v && r_s3.last;
        w_pipe_busy = r_s1_v || r_s2_v || r_s3_v;
    end

    // One restoring division step of 2^(2F) by the determinant magnitude.
    always_comb begin
        w_rem_sh = {r_rem, (r_dcnt == 6'd0)};
        w_qbit   = (w_rem_sh >= {1'b0, r_dmag});
        n_quo    = {r_quo[QUO_BITS-2:0], w_qbit};
        w_qs     = r_dneg ? -$signed({1'b0, n_quo}) : $signed({1'b0, n_quo});
    end

    // Memory, written by the last stage of the pipeline.
    always_ff @(posedge i_clk) begin
        if (w_wr && (r_s3.dst == DST_MEM)) begin
            r_mem[r_s3.dst_addr] <= w_fin;
        end
        r_rd_a <= r_mem[w_rd_a_addr];
        r_rd_b <= r_mem[w_rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_a_ok <= w_rd_a_addr[5] || r_vld[w_rd_a_addr[4:0]];
        r_rd_b_ok <= w_rd_b_addr[5] || r_vld[w_rd_b_addr[4:0]];
        r_s1      <= w_iss;
        r_s2      <= r_s1;
        r_prod    <= w_prod;
        r_s3      <= r_s2;
        if (r_s2_v) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == S_ISSUE);
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            // While finishing, the output register is reloaded below instead.
            if (m_axis_tready && (r_state != S_DONE)) begin
                r_out_v <= 1'b0;
            end
            if (w_wr) begin
                r_ov <= r_ov | w_fin_ov;
                case (r_s3.dst)
                    DST_MEM: begin
                        if (!r_s3.dst_addr[5]) begin
                            r_vld[r_s3.dst_addr[4:0]] <= 1'b1;
                        end
                    end
                    DST_OUT: r_res[r_s3.dst_addr[1:0]] <= w_fin;
                    DST_DET: r_det <= w_fin;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= t_op'(s_axis_tuser[2:0]);
                        r_row    <= s_axis_tuser[4:3];
                        r_vec[0] <= s_axis_tdata[31:0];
                        r_vec[1] <= s_axis_tdata[63:32];
                        r_vec[2] <= s_axis_tdata[95:64];
                        r_vec[3] <= s_axis_tdata[127:96];
                        r_ph     <= 2'd0;
                        r_q      <= 4'd0;
                        r_g      <= 4'd0;
                        r_k      <= 3'd0;
                        r_ov     <= 1'b0;
                        r_sing   <= 1'b0;
                        for (int i = 0; i < 4; i++) begin
                            r_res[i] <= '0;
                        end
                        r_state  <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_k == w_lk) begin
                        r_k <= 3'd0;
                        if (r_g == w_lg) begin
                            r_g     <= 4'd0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_g <= r_g + 4'd1;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_DRAIN: begin
                    // Later phases read what earlier ones wrote back.
                    if (!w_pipe_busy) begin
                        if (r_op == OP_MUL && r_ph == 2'd0) begin
                            r_ph    <= 2'd1;
                            r_state <= S_ISSUE;
                        end else if (r_op == OP_INV) begin
                            case (r_ph)
                                2'd0: begin
                                    r_ph    <= 2'd1;
                                    r_state <= S_ISSUE;
                                end
                                2'd1: begin
                                    r_ph    <= (r_q == 4'd15) ? 2'd2 : 2'd0;
                                    r_q     <= r_q + 4'd1;
                                    r_state <= S_ISSUE;
                                end
                                2'd2: begin
                                    if (r_det == '0) begin
                                        r_sing  <= 1'b1;
                                        r_state <= S_DONE;
                                    end else begin
                                        r_dmag  <= r_det[WORD_BITS-1] ? 32'(-r_det)
                                                                      : 32'(r_det);
                                        r_dneg  <= r_det[WORD_BITS-1];
                                        r_rem   <= '0;
                                        r_quo   <= '0;
                                        r_dcnt  <= 6'd0;
                                        r_state <= S_DIV;
                                    end
                                end
                                default: r_state <= S_DONE;
                            endcase
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= w_qbit ? 32'(w_rem_sh - {1'b0, r_dmag}) : w_rem_sh[31:0];
                    r_quo  <= n_quo;
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == DIV_LAST) begin
                        if (w_qs > Q_MAX) begin
                            r_recip <= t_word'(ACC_MAX);
                            r_ov    <= 1'b1;
                        end else if (w_qs < Q_MIN) begin
                            r_recip <= t_word'(ACC_MIN);
                            r_ov    <= 1'b1;
                        end else begin
                            r_recip <= t_word'(w_qs);
                        end
                        r_ph    <= 2'd3;
                        r_state <= S_ISSUE;
                    end
                end
                S_DONE: begin
                    if (!r_out_v || m_axis_tready) begin
                        r_out_v    <= 1'b1;
                        r_out      <= r_res;
                        r_out_sing <= r_sing;
                        r_out_ov   <= r_ov;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_pipe_busy)
        else $error("pipeline busy while idle");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_det != '0))
        else $error("division entered with zero determinant");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_state == S_DONE))
        else $error("result shown without finishing an item");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_sing) |-> (m_axis_tdata == '0))
        else $error("singular result carries data");
`endif

endmodule

// ----- tb/tb_matrix4_transform_engine.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the 4x4 fixed-point transform engine. A directed
// table walks the extremes and every operation, then random traffic follows.
// Every accepted input transaction is run through a local model of the
// matrix state, and the expected result is queued. Each output transaction
// is compared against the oldest queued result.
module tb_matrix4_transform_engine;
    import mte_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int WORD_MAX     = 32'h7FFFFFFF;
    localparam int WORD_MIN     = 32'h80000000;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_op        op;
        logic [1:0] row;
        int         x;
        int         y;
        int         z;
        int         w;
    } t_request;

    typedef struct {
        int vx;
        int vy;
        int vz;
        int vw;
        bit sing;
        bit ovf;
    } t_response;

    typedef struct {
        t_request  req;
        bit        typed;
        t_response res;
    } t_table_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // x, y, z, w (32 bits each)
    logic [4:0]   s_axis_tuser;   // op (3 bits), row (2 bits)
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // out_x, out_y, out_z, out_w
    logic [1:0]   m_axis_tuser;   // singular, overflow

    matrix4_transform_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    int        mismatch_count;
    int        cycle_count;
    bit        calm;
    bit        sat_seen;
    int        cur_m [16];
    int        opd_m [16];
    t_response pending_results [$];

    always #5 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("matrix4_transform_engine: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("error: %s got %0d (0x%08h) want %0d (0x%08h)", what, got, got, want, want);
        mismatch_count++;
    endtask

    function automatic t_wide mul_wide(int a, int b);
        return t_wide'(a) * t_wide'(b);
    endfunction

    // Floor by the fraction width and saturate to the word range.
    function automatic int settle(t_wide s);
        t_wide q;
        q = s >>> FRAC_BITS;
        if (q > t_wide'(WORD_MAX)) begin
            sat_seen = 1'b1;
            return WORD_MAX;
        end
        if (q < t_wide'(WORD_MIN)) begin
            sat_seen = 1'b1;
            return WORD_MIN;
        end
        return int'(q);
    endfunction

    // Adjugate entry (r,c): signed minor with row c and column r removed.
    function automatic int adjugate_entry(int r, int c);
        int    pa [6] = '{0, 1, 2, 0, 2, 1};
        int    pb [6] = '{1, 2, 0, 2, 1, 0};
        int    pc [6] = '{2, 0, 1, 1, 0, 2};
        int    ps [6] = '{1, 1, 1, -1, -1, -1};
        int    rows [3];
        int    cols [3];
        int    n;
        int    p;
        int    sgn;
        t_wide s;
        t_wide tp;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != c) rows[n++] = i;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != r) cols[n++] = i;
        s = '0;
        for (int k = 0; k < 6; k++) begin
            p   = settle(mul_wide(cur_m[cols[pa[k]]*4 + rows[0]],
                                  cur_m[cols[pb[k]]*4 + rows[1]]));
            sgn = ps[k] * (((r + c) & 1) ? -1 : 1);
            tp  = (sgn < 0) ? -t_wide'(p) : t_wide'(p);
            s   = s + tp * t_wide'(cur_m[cols[pc[k]]*4 + rows[2]]);
        end
        return settle(s);
    endfunction

    // Returns 1 when the determinant is zero and the matrix is kept.
    function automatic bit invert_in_place();
        int     cof [16];
        int     det;
        int     recip;
        longint quo;
        t_wide  s;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                cof[c*4 + r] = adjugate_entry(r, c);
        s = '0;
        for (int i = 0; i < 4; i++) s = s + mul_wide(cur_m[i], cof[i*4]);
        det = settle(s);
        if (det == 0) return 1'b1;
        quo = (longint'(1) << (2*FRAC_BITS)) / longint'(det);
        if (quo > longint'(WORD_MAX)) begin
            recip = WORD_MAX;
            sat_seen = 1'b1;
        end else if (quo < longint'(WORD_MIN)) begin
            recip = WORD_MIN;
            sat_seen = 1'b1;
        end else begin
            recip = int'(quo);
        end
        for (int i = 0; i < 16; i++) cur_m[i] = settle(mul_wide(cof[i], recip));
        return 1'b0;
    endfunction

    // Advances the kept matrices by one request and returns its result.
    function automatic t_response apply_request(t_request q);
        t_response rsp;
        int        v [4];
        int        o [4];
        int        tmp [16];
        t_wide     s;
        v = '{q.x, q.y, q.z, q.w};
        o = '{0, 0, 0, 0};
        rsp = '{0, 0, 0, 0, 1'b0, 1'b0};
        sat_seen = 1'b0;
        case (q.op)
            OP_IDENT: begin
                for (int i = 0; i < 16; i++) cur_m[i] = (i % 5 == 0) ? 32'h10000 : 0;
            end
            OP_SCALE: begin
                for (int i = 0; i < 12; i++) cur_m[i] = settle(mul_wide(cur_m[i], v[i/4]));
            end
            OP_TRANS: begin
                for (int r = 0; r < 4; r++) begin
                    s = mul_wide(cur_m[12 + r], 32'h10000);
                    for (int j = 0; j < 3; j++) s = s + mul_wide(cur_m[j*4 + r], v[j]);
                    cur_m[12 + r] = settle(s);
                end
            end
            OP_LOAD: begin
                for (int j = 0; j < 4; j++) opd_m[j*4 + q.row] = v[j];
            end
            OP_MUL: begin
                for (int i = 0; i < 16; i++) begin
                    s = '0;
                    for (int j = 0; j < 4; j++)
                        s = s + mul_wide(opd_m[(i/4)*4 + j], cur_m[(i%4) + j*4]);
                    tmp[i] = settle(s);
                end
                cur_m = tmp;
            end
            OP_INV: begin
                rsp.sing = invert_in_place();
            end
            OP_XFORM: begin
                for (int r = 0; r < 4; r++) begin
                    s = '0;
                    for (int j = 0; j < 4; j++) s = s + mul_wide(v[j], cur_m[j*4 + r]);
                    o[r] = settle(s);
                end
            end
            default: begin
                for (int j = 0; j < 4; j++) o[j] = cur_m[j*4 + q.row];
            end
        endcase
        rsp.vx  = o[0];
        rsp.vy  = o[1];
        rsp.vz  = o[2];
        rsp.vw  = o[3];
        rsp.ovf = sat_seen;
        return rsp;
    endfunction

    function automatic int pick_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            2: return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
            3: return ($urandom_range(0, 8) - 4) * 32'h10000;
            4: return $urandom_range(0, 32'h7FFF) - 32'h4000 + 32'h10000;
            default: return $urandom_range(0, 2) - 1;
        endcase
    endfunction

    function automatic t_op pick_op();
        int n;
        n = $urandom_range(0, 99);
        if (n < 5)  return OP_IDENT;
        if (n < 15) return OP_SCALE;
        if (n < 25) return OP_TRANS;
        if (n < 50) return OP_LOAD;
        if (n < 62) return OP_MUL;
        if (n < 67) return OP_INV;
        if (n < 85) return OP_XFORM;
        return OP_READ;
    endfunction

    function automatic int pick_gap();
        int n;
        if (calm) return 0;
        n = $urandom_range(0, 99);
        if (n < 60) return 0;
        if (n < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one request and waits for its handshake. The model runs at
    // the accepting edge, so the expectation is queued long before the result.
    task automatic issue(t_request q, bit typed, t_response want);
        int        gap;
        t_response got_model;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {q.w, q.z, q.y, q.x};
        s_axis_tuser  <= {q.row, q.op};
        do @(posedge i_clk); while (!s_axis_tready);
        got_model = apply_request(q);
        pending_results.push_back(typed ? want : got_model);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_response want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] != want.vx)
                    report_mismatch("out_x", m_axis_tdata[31:0], want.vx);
                if (m_axis_tdata[63:32] != want.vy)
                    report_mismatch("out_y", m_axis_tdata[63:32], want.vy);
                if (m_axis_tdata[95:64] != want.vz)
                    report_mismatch("out_z", m_axis_tdata[95:64], want.vz);
                if (m_axis_tdata[127:96] != want.vw)
                    report_mismatch("out_w", m_axis_tdata[127:96], want.vw);
                if (m_axis_tuser[0] != want.sing)
                    report_mismatch("singular", m_axis_tuser[0], want.sing);
                if (m_axis_tuser[1] != want.ovf)
                    report_mismatch("overflow", m_axis_tuser[1], want.ovf);
            end
        end
    end

    // Receiver stalls in bursts; ready stays high while the calm stretch runs.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = $urandom_range(1, 30);
            repeat (hold) begin
                @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            if (calm) hold = 0;
            repeat (hold) begin
                @(posedge i_clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    initial begin
        t_table_row tbl [$];
        t_request   q;
        t_response  none;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        calm           = 1'b0;
        sat_seen       = 1'b0;
        none           = '{0, 0, 0, 0, 1'b0, 1'b0};
        for (int i = 0; i < 16; i++) begin
            cur_m[i] = 0;
            opd_m[i] = 0;
        end

        // Reset state, a singular invert, identity, extremes, every operation.
        tbl.push_back('{'{OP_READ, 2'd0, 0, 0, 0, 0}, 1'b1, none});
        tbl.push_back('{'{OP_INV, 2'd0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 1'b1, 1'b0}});
        tbl.push_back('{'{OP_XFORM, 2'd3, WORD_MAX, WORD_MIN, -1, 1}, 1'b1, none});
        tbl.push_back('{'{OP_IDENT, 2'd0, 0, 0, 0, 0}, 1'b1, none});
        tbl.push_back('{'{OP_READ, 2'd2, 0, 0, 0, 0}, 1'b1, '{0, 0, 32'h10000, 0, 1'b0, 1'b0}});
        tbl.push_back('{'{OP_XFORM, 2'd0, WORD_MAX, WORD_MIN, 0, -1}, 1'b1,
                        '{WORD_MAX, WORD_MIN, 0, -1, 1'b0, 1'b0}});
        tbl.push_back('{'{OP_SCALE, 2'd1, WORD_MAX, WORD_MIN, 32'h10000, 0}, 1'b0, none});
        tbl.push_back('{'{OP_TRANS, 2'd2, WORD_MAX, WORD_MIN, 32'h30000, 0}, 1'b0, none});
        for (int r = 0; r < 4; r++)
            tbl.push_back('{'{OP_READ, 2'(r), 0, 0, 0, 0}, 1'b0, none});
        tbl.push_back('{'{OP_LOAD, 2'd0, WORD_MAX, WORD_MIN, -1, 1}, 1'b0, none});
        tbl.push_back('{'{OP_LOAD, 2'd1, WORD_MIN, WORD_MAX, 1, -1}, 1'b0, none});
        tbl.push_back('{'{OP_LOAD, 2'd2, 32'h10000, 0, 32'h20000, 0}, 1'b0, none});
        tbl.push_back('{'{OP_LOAD, 2'd3, 0, 0, 0, 32'h10000}, 1'b0, none});
        tbl.push_back('{'{OP_MUL, 2'd0, 0, 0, 0, 0}, 1'b0, none});
        tbl.push_back('{'{OP_INV, 2'd0, 0, 0, 0, 0}, 1'b0, none});
        tbl.push_back('{'{OP_IDENT, 2'd3, 0, 0, 0, 0}, 1'b0, none});
        // Small diagonal: the determinant floors to one, so its reciprocal
        // saturates.
        tbl.push_back('{'{OP_SCALE, 2'd0, 1700, 1700, 1700, 0}, 1'b0, none});
        tbl.push_back('{'{OP_INV, 2'd0, 0, 0, 0, 0}, 1'b0, none});
        tbl.push_back('{'{OP_READ, 2'd0, 0, 0, 0, 0}, 1'b0, none});
        tbl.push_back('{'{OP_IDENT, 2'd0, 0, 0, 0, 0}, 1'b0, none});
        tbl.push_back('{'{OP_SCALE, 2'd0, 32'h20000, 32'h30000, 32'h40000, 0}, 1'b0, none});
        tbl.push_back('{'{OP_INV, 2'd0, 0, 0, 0, 0}, 1'b0, none});
        tbl.push_back('{'{OP_READ, 2'd1, 0, 0, 0, 0}, 1'b0, none});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (tbl[i]) issue(tbl[i].req, tbl[i].typed, tbl[i].res);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 500 && n < 620);
            q.op  = pick_op();
            q.row = 2'($urandom_range(0, 3));
            q.x   = pick_word();
            q.y   = pick_word();
            q.z   = pick_word();
            q.w   = pick_word();
            issue(q, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("matrix4_transform_engine: match");
        end else begin
            $display("matrix4_transform_engine: mismatch");
        end
        $finish;
    end

endmodule

// ----- matrix4_transform_engine.f -----
rtl/mte_pkg.sv
rtl/matrix4_transform_engine.sv
tb/tb_matrix4_transform_engine.sv
